// ----- sv/bsoc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsoc_pkg
// Shared widths, constants and the OCV-to-percent curve for the battery
// state-of-charge estimator.
// ----------------------------------------------------------------------------
package bsoc_pkg;

  localparam int VOLT_W  = 16;
  localparam int CUR_W   = 16;
  localparam int RES_W   = 12;
  localparam int PCT_W   = 7;

  // current * resistance, max 65535 * 4095 < 2**28
  localparam int PROD_W  = CUR_W + RES_W;
  // IR drop in mV after /1000, max 268365
  localparam int IRQ_W   = 19;
  // open-circuit voltage, max 65535 + 268365
  localparam int OCV_W   = 20;

  // floor(p / 1000) = (p * DIV_RECIP) >> DIV_SHIFT, exact for p < 2**28
  localparam int DIV_SHIFT = 38;
  localparam int RECIP_W   = 29;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 29'd274877907;
  localparam int IRP_W     = PROD_W + RECIP_W;

  localparam int CURVE_POINTS = 12;
  localparam int NSEG         = CURVE_POINTS - 1;
  localparam int SEG_W        = 4;
  localparam int PT_W         = 4;

  // offset inside one segment, max span 1200
  localparam int DIFF_W   = 11;
  // per-segment reciprocal of span/rise, scaled by 2**SEG_SHIFT
  localparam int SEG_SHIFT = 20;
  localparam int SRCP_W    = 16;
  localparam int SCL_W     = DIFF_W + SRCP_W;

  localparam logic [RES_W-1:0] RES_RESET = 12'd100;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  typedef logic [OCV_W-1:0] ocv_t;
  typedef logic [PCT_W-1:0] pct_t;

  localparam logic [VOLT_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    16'd25200, 16'd24600, 16'd24000, 16'd23700, 16'd23400, 16'd23100,
    16'd22800, 16'd22500, 16'd22200, 16'd21600, 16'd20400, 16'd19600
  };

  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40,  7'd30, 7'd20, 7'd10, 7'd5,  7'd0
  };

  // ceil(2**20 / (span / rise)) for each segment; divisors 60, 30, 240, 160
  localparam logic [SRCP_W-1:0] SEG_RECIP [NSEG] = '{
    16'd17477, 16'd17477, 16'd34953, 16'd34953, 16'd34953, 16'd34953,
    16'd34953, 16'd34953, 16'd17477, 16'd4370,  16'd6554
  };

endpackage

// ----- sv/bsoc_if.sv -----
// ----------------------------------------------------------------------------
// bsoc channel interfaces
// Valid/ready channels for the measurement input and the SOC result.
// ----------------------------------------------------------------------------
interface bsoc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsoc_pkg::VOLT_W-1:0]   pack_voltage_mv;
  logic [bsoc_pkg::CUR_W-1:0]    battery_current_ma;

  modport source (output valid, output pack_voltage_mv, output battery_current_ma,
                  input ready);
  modport sink   (input valid, input pack_voltage_mv, input battery_current_ma,
                  output ready);
endinterface

interface bsoc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsoc_pkg::PCT_W-1:0]    soc_percent;

  modport source (output valid, output soc_percent, input ready);
  modport sink   (input valid, input soc_percent, output ready);
endinterface

// ----- sv/bsoc_ocv.sv -----
// ----------------------------------------------------------------------------
// bsoc_ocv
// Three-stage IR compensation: current * resistance, /1000 by reciprocal
// multiply, then add to the measured pack voltage.
// ----------------------------------------------------------------------------
module bsoc_ocv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bsoc_pkg::RES_W-1:0]    res_mohm,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsoc_pkg::VOLT_W-1:0]   in_volt,
  input  logic [bsoc_pkg::CUR_W-1:0]    in_cur,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bsoc_pkg::ocv_t                out_ocv
);

  logic                          v1_r, v2_r, v3_r;
  logic                          rdy1, rdy2, rdy3;
  logic [bsoc_pkg::PROD_W-1:0]   prod1_r;
  logic [bsoc_pkg::VOLT_W-1:0]   volt1_r, volt2_r;
  logic [bsoc_pkg::IRP_W-1:0]    irp;
  logic [bsoc_pkg::IRQ_W-1:0]    irq_nxt, irq2_r;
  bsoc_pkg::ocv_t                ocv_nxt, ocv3_r;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    rdy3 = !v3_r || out_ready;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
  end

  assign in_ready  = rdy1;
  assign out_valid = v3_r;
  assign out_ocv   = ocv3_r;

  always_comb begin
    irp     = bsoc_pkg::IRP_W'(prod1_r) * bsoc_pkg::IRP_W'(bsoc_pkg::DIV_RECIP);
    irq_nxt = irp[bsoc_pkg::DIV_SHIFT +: bsoc_pkg::IRQ_W];
    ocv_nxt = bsoc_pkg::OCV_W'(volt2_r) + bsoc_pkg::OCV_W'(irq2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      prod1_r <= bsoc_pkg::PROD_W'(in_cur) * bsoc_pkg::PROD_W'(res_mohm);
      volt1_r <= in_volt;
    end
    if (rdy2 && v1_r) begin
      irq2_r  <= irq_nxt;
      volt2_r <= volt1_r;
    end
    if (rdy3 && v2_r) begin
      ocv3_r  <= ocv_nxt;
    end
  end

endmodule

// ----- sv/bsoc_curve.sv -----
// ----------------------------------------------------------------------------
// bsoc_curve
// Three-stage curve lookup: segment search, scaled offset multiply, then
// add to the segment's low percent with full/empty overrides.
// ----------------------------------------------------------------------------
module bsoc_curve (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bsoc_pkg::ocv_t                in_ocv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bsoc_pkg::pct_t                out_soc
);

  logic                          v4_r, v5_r, v6_r;
  logic                          rdy4, rdy5, rdy6;

  logic [bsoc_pkg::SEG_W-1:0]    seg_nxt, seg4_r, seg5_r;
  logic [bsoc_pkg::DIFF_W-1:0]   diff_nxt, diff4_r;
  logic                          full_nxt, empty_nxt;
  logic                          full4_r, empty4_r, full5_r, empty5_r;
  logic [bsoc_pkg::SCL_W-1:0]    scl5_r;
  logic [bsoc_pkg::PT_W-1:0]     lo_pt;
  logic [bsoc_pkg::PCT_W:0]      sum;
  bsoc_pkg::pct_t                soc_nxt, soc6_r;
  bsoc_pkg::ocv_t                lo_mv;
  bsoc_pkg::ocv_t                offs;

  always_comb begin
    rdy6 = !v6_r || out_ready;
    rdy5 = !v5_r || rdy6;
    rdy4 = !v4_r || rdy5;
  end

  assign in_ready  = rdy4;
  assign out_valid = v6_r;
  assign out_soc   = soc6_r;

  // segment k is the first whose lower point is at or below ocv
  always_comb begin
    full_nxt  = in_ocv >= bsoc_pkg::OCV_W'(bsoc_pkg::CURVE_MV[0]);
    empty_nxt = in_ocv <= bsoc_pkg::OCV_W'(bsoc_pkg::CURVE_MV[bsoc_pkg::CURVE_POINTS-1]);
    seg_nxt   = '0;
    for (int k = bsoc_pkg::NSEG - 1; k >= 0; k--) begin
      if (in_ocv >= bsoc_pkg::OCV_W'(bsoc_pkg::CURVE_MV[k+1]))
        seg_nxt = bsoc_pkg::SEG_W'(k);
    end
    lo_mv    = bsoc_pkg::OCV_W'(bsoc_pkg::CURVE_MV[bsoc_pkg::PT_W'(seg_nxt) + 1'b1]);
    offs     = in_ocv - lo_mv;
    diff_nxt = (full_nxt || empty_nxt) ? '0 : offs[bsoc_pkg::DIFF_W-1:0];
  end

  always_comb begin
    lo_pt = bsoc_pkg::PT_W'(seg5_r) + 1'b1;
    sum   = (bsoc_pkg::PCT_W+1)'(bsoc_pkg::CURVE_PCT[lo_pt])
          + (bsoc_pkg::PCT_W+1)'(scl5_r[bsoc_pkg::SEG_SHIFT +: bsoc_pkg::PCT_W]);
    if (full5_r)
      soc_nxt = bsoc_pkg::PCT_FULL;
    else if (empty5_r)
      soc_nxt = bsoc_pkg::PCT_EMPTY;
    else if (sum > (bsoc_pkg::PCT_W+1)'(bsoc_pkg::PCT_FULL))
      soc_nxt = bsoc_pkg::PCT_FULL;
    else
      soc_nxt = sum[bsoc_pkg::PCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      seg4_r   <= seg_nxt;
      diff4_r  <= diff_nxt;
      full4_r  <= full_nxt;
      empty4_r <= empty_nxt;
    end
    if (rdy5 && v4_r) begin
      scl5_r   <= bsoc_pkg::SCL_W'(diff4_r) * bsoc_pkg::SCL_W'(bsoc_pkg::SEG_RECIP[seg4_r]);
      seg5_r   <= seg4_r;
      full5_r  <= full4_r;
      empty5_r <= empty4_r;
    end
    if (rdy6 && v5_r) begin
      soc6_r   <= soc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> seg4_r < bsoc_pkg::SEG_W'(bsoc_pkg::NSEG))
    else $error("segment index out of range");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !full5_r && !empty5_r |->
      scl5_r[bsoc_pkg::SCL_W-1:bsoc_pkg::SEG_SHIFT] <= 7'd10)
    else $error("interpolation step exceeds segment rise");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !rdy6 |=> v5_r && $stable(scl5_r) && $stable(seg5_r))
    else $error("stage 5 word lost under stall");

  a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> soc6_r <= bsoc_pkg::PCT_FULL)
    else $error("soc above 100 percent");
`endif

endmodule

// ----- sv/battery_soc_from_voltage_top.sv -----
// Throughput: one word per cycle while the result side is ready; every
// stage has its own valid bit and advances when empty or when the stage
// after it advances.
// Reset (rst_n low, synchronous) empties the pipeline and sets the
// internal resistance to 100 milliohm; no clearing pass is needed.
// ----------------------------------------------------------------------------
// battery_soc_from_voltage_top
// State-of-charge estimate from pack voltage and current with IR
// compensation and a 12-point OCV curve.
// ----------------------------------------------------------------------------
module battery_soc_from_voltage_top (
  input  logic                          clk,
  input  logic                          rst_n,
  bsoc_in_if.sink                       in_ch,
  bsoc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [bsoc_pkg::RES_W-1:0]    cfg_wdata
);

  logic [bsoc_pkg::RES_W-1:0]  res_r;
  logic                        ocv_valid;
  logic                        ocv_ready;
  bsoc_pkg::ocv_t              ocv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= bsoc_pkg::RES_RESET;
    end else if (cfg_we) begin
      res_r <= cfg_wdata;
    end
  end

  bsoc_ocv u_ocv (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_mohm  (res_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_volt   (in_ch.pack_voltage_mv),
    .in_cur    (in_ch.battery_current_ma),
    .out_valid (ocv_valid),
    .out_ready (ocv_ready),
    .out_ocv   (ocv)
  );

  bsoc_curve u_curve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ocv_valid),
    .in_ready  (ocv_ready),
    .in_ocv    (ocv),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_soc   (out_ch.soc_percent)
  );

endmodule

// ----- verif/bsoc_soc_checker.sv -----
// ----------------------------------------------------------------------------
// bsoc_soc_checker
// Watches the measurement and SOC channels and the resistance write port,
// predicts each SOC word from the IR-compensated voltage and the OCV curve,
// and compares it with the word the block returns, in order.
// ----------------------------------------------------------------------------
module bsoc_soc_checker import bsoc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  bsoc_in_if               in_mon,
  bsoc_out_if              out_mon,
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_wdata,
  output int               pending,
  output int               fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [VOLT_W-1:0] volt;
    logic [CUR_W-1:0]  cur;
    logic [RES_W-1:0]  res;
    pct_t              soc;
  } soc_expect_t;

  soc_expect_t       soc_q[$];
  soc_expect_t       fresh, oldest;
  logic [RES_W-1:0]  res_copy;
  int                errors;

  assign fail_count = errors;

  initial begin
    errors   = 0;
    pending  = 0;
    res_copy = RES_RESET;
  end

  // ocv = v + floor(i * r / 1000), then the descending curve with a floored
  // linear fit between neighbors
  function automatic pct_t soc_of_measurement(logic [VOLT_W-1:0] volt,
                                              logic [CUR_W-1:0] cur,
                                              logic [RES_W-1:0] res);
    logic [31:0] ocv;
    logic [31:0] lvl;
    ocv = 32'(volt) + (32'(cur) * 32'(res)) / 32'd1000;
    if (ocv >= 32'(CURVE_MV[0])) return PCT_FULL;
    if (ocv <= 32'(CURVE_MV[CURVE_POINTS-1])) return PCT_EMPTY;
    for (int k = 0; k < NSEG; k++) begin
      if (ocv <= 32'(CURVE_MV[k]) && ocv >= 32'(CURVE_MV[k+1])) begin
        lvl = 32'(CURVE_PCT[k+1]) +
              ((ocv - 32'(CURVE_MV[k+1])) * (32'(CURVE_PCT[k]) - 32'(CURVE_PCT[k+1]))) /
              (32'(CURVE_MV[k]) - 32'(CURVE_MV[k+1]));
        if (lvl > 32'(PCT_FULL)) return PCT_FULL;
        return pct_t'(lvl);
      end
    end
    return PCT_EMPTY;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      res_copy <= RES_RESET;
      soc_q.delete();
    end else begin
      if (cfg_we) res_copy <= cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        fresh.volt = in_mon.pack_voltage_mv;
        fresh.cur  = in_mon.battery_current_ma;
        fresh.res  = res_copy;
        fresh.soc  = soc_of_measurement(fresh.volt, fresh.cur, fresh.res);
        soc_q.push_back(fresh);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (soc_q.size() == 0) begin
          report_mismatch($sformatf("soc word %0d with nothing expected",
                                    out_mon.soc_percent));
        end else begin
          oldest = soc_q.pop_front();
          if (out_mon.soc_percent !== oldest.soc)
            report_mismatch($sformatf("v=%0d i=%0d r=%0d: soc %0d, want %0d",
                                      oldest.volt, oldest.cur, oldest.res,
                                      out_mon.soc_percent, oldest.soc));
        end
      end
    end
    pending <= soc_q.size();
  end

endmodule

// ----- verif/tb_battery_soc_from_voltage_top.sv -----
// ----------------------------------------------------------------------------
// tb_battery_soc_from_voltage_top
// Drives measurement words and resistance settings into the SOC estimator
// with random idling on both channels, a long output stall and drained
// phase changes; the checker predicts and compares every SOC word.
// ----------------------------------------------------------------------------
module tb_battery_soc_from_voltage_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bsoc_pkg::*;

  localparam int LATENCY        = 6;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 250;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [RES_W-1:0] cfg_wdata;
  logic             calm;
  logic             hold_request;
  logic [RES_W-1:0] res_now;
  int               pending;
  int               fail_count;
  int               quiet;

  bsoc_in_if  in_ch ();
  bsoc_out_if out_ch ();

  battery_soc_from_voltage_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bsoc_soc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always #4 clk = ~clk;

  // no word moving on either channel for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic send_word(input logic [VOLT_W-1:0] volt, input logic [CUR_W-1:0] cur);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.pack_voltage_mv    <= volt;
    in_ch.battery_current_ma <= cur;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_resistance(input logic [RES_W-1:0] res);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= res;
    @(posedge clk);
    cfg_we    <= 1'b0;
    res_now = res;
  endtask

  // mostly aims the compensated voltage into the curve, some near the knees,
  // the rest raw 16-bit noise
  task automatic pick_measurement(output logic [VOLT_W-1:0] volt,
                                  output logic [CUR_W-1:0] cur);
    int unsigned shape, spread, target, ir;
    shape  = $urandom_range(99);
    spread = $urandom_range(99);
    if (spread < 40) cur = CUR_W'($urandom_range(3000));
    else if (spread < 80) cur = CUR_W'($urandom_range(20000));
    else cur = CUR_W'($urandom);
    if (shape < 20) begin
      volt = VOLT_W'($urandom);
    end else begin
      if (shape < 35)
        target = 32'(CURVE_MV[$urandom_range(CURVE_POINTS-1)]) + $urandom_range(4) - 2;
      else
        target = $urandom_range(25400, 19400);
      ir = (32'(cur) * 32'(res_now)) / 1000;
      if (ir > target) begin
        cur = '0;
        ir  = 0;
      end
      volt = VOLT_W'(target - ir);
    end
  endtask

  initial begin : stimulus
    logic [VOLT_W-1:0] volt;
    logic [CUR_W-1:0]  cur;
    logic [RES_W-1:0]  res;
    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_wdata                <= '0;
    calm                     <= 1'b0;
    hold_request             <= 1'b0;
    in_ch.valid              <= 1'b0;
    in_ch.pack_voltage_mv    <= '0;
    in_ch.battery_current_ma <= '0;
    res_now = RES_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset resistance: every curve point, both ends, just inside, mid-segment
    for (int k = 0; k < CURVE_POINTS; k++) send_word(CURVE_MV[k], '0);
    send_word(16'd25199, '0);
    send_word(16'd19601, '0);
    send_word(16'd22350, '0);
    send_word('0, '0);
    send_word('1, '1);
    send_word(16'd20000, 16'd20000);
    send_word(16'd19599, 16'd10);

    // widest IR term
    write_resistance('1);
    send_word('1, '1);
    send_word('0, '1);
    send_word('0, 16'd1);

    // no compensation
    write_resistance('0);
    send_word(16'd25200, '1);
    send_word(16'd19601, '1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: res = '0;
        1: res = '1;
        2: res = 12'd250;
        4: res = 12'd1;
        6: res = 12'd2000;
        7: res = RES_RESET;
        default: res = RES_W'($urandom_range(4095));
      endcase
      write_resistance(res);
      // one phase runs without idling and with a long result stall
      if (p == 2) begin
        calm         <= 1'b1;
        hold_request <= 1'b1;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick_measurement(volt, cur);
        send_word(volt, cur);
      end
      if (p == 2) calm <= 1'b0;
    end

    drain_results();
    repeat (LATENCY * 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
